>>> rtl/core/ais_pkg.sv
// ----------------------------------------------------------------------------
// ais_pkg
// Shared types and constants for the ascending integer sorter.
// ----------------------------------------------------------------------------
package ais_pkg;

   localparam int CAPACITY    = 64;
   localparam int VALUE_WIDTH = 32;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   typedef enum logic {
      ST_LOAD,
      ST_EMIT
   } state_type;

   // control broadcast to every cell
   typedef struct packed {
      logic ins;   // insert the incoming value
      logic pop;   // shift the chain toward the head
   } cell_ctrl_type;

   // what one cell shows its neighbors
   typedef struct packed {
      logic      valid;
      logic      gt;     // stored value is greater than the incoming value
      value_type value;
   } cell_link_type;

   // chain status toward the controller
   typedef struct packed {
      logic      head_valid;
      logic      head_last;
      logic      full;
      value_type head_value;
   } chain_status_type;

endpackage

>>> rtl/core/ais_cell.sv
// ----------------------------------------------------------------------------
// ais_cell
// One slot of the insertion chain: holds one element and its valid bit.
// ----------------------------------------------------------------------------
module ais_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  ais_pkg::cell_ctrl_type ctrl,
   input  ais_pkg::value_type     new_value,
   input  ais_pkg::cell_link_type prev_link,
   input  ais_pkg::cell_link_type next_link,
   output ais_pkg::cell_link_type link
);

   logic               valid_ff, valid_in;
   ais_pkg::value_type value_ff, value_in;
   logic               gt;

   assign gt   = valid_ff && (value_ff > new_value);
   assign link = '{valid: valid_ff, gt: gt, value: value_ff};

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctrl.pop) begin
         valid_in = next_link.valid;
         value_in = next_link.value;
      end else if (ctrl.ins) begin
         valid_in = valid_ff || prev_link.valid;
         if (prev_link.gt) begin
            // everything from here up moves one slot away from the head
            value_in = prev_link.value;
         end else if ((gt || !valid_ff) && prev_link.valid) begin
            value_in = new_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

endmodule

>>> rtl/core/ais_chain.sv
// ----------------------------------------------------------------------------
// ais_chain
// Row of insertion cells kept in ascending order from the head.
// ----------------------------------------------------------------------------
module ais_chain (
   input  logic                      clock,
   input  logic                      reset,
   input  ais_pkg::cell_ctrl_type    ctrl,
   input  ais_pkg::value_type        new_value,
   output ais_pkg::chain_status_type status
);

   ais_pkg::cell_link_type links [ais_pkg::CAPACITY];

   genvar g;
   generate
      for (g = 0; g < ais_pkg::CAPACITY; g++) begin : g_cell
         ais_pkg::cell_link_type prev_link;
         ais_pkg::cell_link_type next_link;

         if (g == 0) begin : g_head
            assign prev_link = '{valid: 1'b1, gt: 1'b0, value: '0};
         end else begin : g_body
            assign prev_link = links[g-1];
         end

         if (g == ais_pkg::CAPACITY - 1) begin : g_tail
            assign next_link = '{valid: 1'b0, gt: 1'b0, value: '0};
         end else begin : g_inner
            assign next_link = links[g+1];
         end

         ais_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .new_value (new_value),
            .prev_link (prev_link),
            .next_link (next_link),
            .link      (links[g])
         );
      end
   endgenerate

   assign status.head_valid = links[0].valid;
   assign status.head_value = links[0].value;
   assign status.head_last  = !links[1].valid;
   assign status.full       = links[ais_pkg::CAPACITY-1].valid;

endmodule

>>> rtl/core/ascending_integer_sorter.sv
// ----------------------------------------------------------------------------
// ascending_integer_sorter
// Collects a set of signed integers and returns it in ascending order.
// ----------------------------------------------------------------------------
//  channel  dir  tdata              tlast     tuser
//  req      in   value[31:0]        last_in   -
//  rsp      out  sorted_value[31:0] last_out  truncated
//
//  loading accepts one element per cycle: each cell of the chain compares
//  against the new element in parallel and the larger ones move up one slot.
//  the first result is valid in the cycle right after the last element is taken;
//  results then leave the chain head at one per cycle while rsp_tready is high.
//  req_tready is low while a set is being emitted; a stall on rsp holds the chain.
//  reset is synchronous and empties the chain.
// ----------------------------------------------------------------------------
module ascending_integer_sorter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] sorted_value
   output logic        rsp_tlast,
   output logic        rsp_tuser    // [0] truncated
);

   ais_pkg::state_type        state_ff, state_in;
   logic                      overflow_ff, overflow_in;
   ais_pkg::cell_ctrl_type    ctrl;
   ais_pkg::chain_status_type status;
   logic                      req_fire, rsp_fire;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   ais_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .new_value (ais_pkg::value_type'(req_tdata)),
      .status    (status)
   );

   always_comb begin
      state_in    = state_ff;
      overflow_in = overflow_ff;
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      ctrl        = '{ins: 1'b0, pop: 1'b0};
      unique case (state_ff)
         ais_pkg::ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               // a full chain drops the element
               ctrl.ins = !status.full;
               if (status.full) begin
                  overflow_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in = ais_pkg::ST_EMIT;
               end
            end
         end
         ais_pkg::ST_EMIT: begin
            rsp_tvalid = status.head_valid;
            ctrl.pop   = status.head_valid && rsp_tready;
            if (status.head_valid && rsp_tready && status.head_last) begin
               state_in    = ais_pkg::ST_LOAD;
               overflow_in = 1'b0;
            end
         end
         default: begin
            state_in = ais_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ais_pkg::ST_LOAD;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         overflow_ff <= overflow_in;
      end
   end

   assign rsp_tdata = status.head_value;
   assign rsp_tlast = status.head_last;
   assign rsp_tuser = overflow_ff;

   // no loading while a set is being emitted
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while results pending");

   // a closing element always leaves something to emit
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> rsp_tvalid)
      else $error("set closed with no result");

   // the chain is empty once the last result has left
   a_empty_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_tlast) |=> (!rsp_tvalid && !status.head_valid))
      else $error("chain not empty after final transaction");

   // dropping an element marks the set as truncated
   a_overflow_flag: assert property (@(posedge clock) disable iff (reset)
      (req_fire && status.full) |=> overflow_ff)
      else $error("dropped element not flagged");

endmodule

>>> sim/sorter_checker.sv
// ----------------------------------------------------------------------------
// sorter_checker
// Watches both streams of the sorter. Accepted request transactions are
// collected per set, and the closing one triggers a sort of the set. Each
// response transaction is then compared against the oldest predicted element.
// ----------------------------------------------------------------------------
module sorter_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [31:0] sorted_value
   input  logic        rsp_tlast,
   input  logic        rsp_tuser,   // [0] truncated
   output int          fail_count,
   output int          pending
);

   typedef struct {
      ais_pkg::value_type value;
      logic               last;
      logic               trunc;
   } sorted_elem_type;

   ais_pkg::value_type set_elems [ais_pkg::CAPACITY];
   int                 set_count;
   logic               set_dropped;
   sorted_elem_type    sorted_expect [$];

   always @(posedge clock) begin
      sorted_elem_type    want;
      ais_pkg::value_type moving;
      int                 j;
      if (reset) begin
         set_count   = 0;
         set_dropped = 1'b0;
         fail_count  = 0;
         sorted_expect.delete();
      end else begin
         // responses first: elements predicted at this edge cannot be due yet
         if (rsp_tvalid && rsp_tready) begin
            if (sorted_expect.size() == 0) begin
               $error("unexpected response transaction: sorted_value %0d",
                      $signed(rsp_tdata));
               fail_count++;
            end else begin
               want = sorted_expect.pop_front();
               if (rsp_tdata !== want.value) begin
                  $error("sorted_value: expected %0d, actual %0d",
                         want.value, $signed(rsp_tdata));
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_out: expected %0b, actual %0b", want.last, rsp_tlast);
                  fail_count++;
               end
               if (rsp_tuser !== want.trunc) begin
                  $error("truncated: expected %0b, actual %0b", want.trunc, rsp_tuser);
                  fail_count++;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            if (set_count < ais_pkg::CAPACITY) begin
               set_elems[set_count] = req_tdata;
               set_count++;
            end else begin
               set_dropped = 1'b1;
            end
            if (req_tlast) begin
               // insertion sort, signed order
               for (int i = 1; i < set_count; i++) begin
                  moving = set_elems[i];
                  j = i;
                  while (j > 0 && set_elems[j-1] > moving) begin
                     set_elems[j] = set_elems[j-1];
                     j--;
                  end
                  set_elems[j] = moving;
               end
               for (int k = 0; k < set_count; k++) begin
                  want.value = set_elems[k];
                  want.last  = (k == set_count - 1);
                  want.trunc = set_dropped;
                  sorted_expect.push_back(want);
               end
               set_count   = 0;
               set_dropped = 1'b0;
            end
         end
      end
      pending = sorted_expect.size();
   end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives sets of signed integers into the sorter: a few directed sets first
// (extreme values, duplicates, overflow of the store), then random sets.
// Both streams idle at random. The checker predicts the sorted output and
// reports mismatches, and this top gives the final verdict.
// ----------------------------------------------------------------------------
module testbench;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] value
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [31:0] sorted_value
   logic        rsp_tlast;
   logic        rsp_tuser;         // [0] truncated

   int   fail_count;
   int   pending;
   int   items_sent = 0;
   int   set_no;
   logic quiet = 1'b0;             // no idling on either side while high

   always #10 clock = ~clock;

   ascending_integer_sorter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   sorter_checker sort_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always @(posedge clock) begin
      rsp_tready <= quiet || ($urandom_range(99) >= 38);
   end

   function automatic ais_pkg::value_type pick_value();
      ais_pkg::value_type v;
      case ($urandom_range(3))
         0: v = $urandom_range(8) - 4;   // narrow range, many duplicates
         1: begin
            case ($urandom_range(3))
               0: v = 32'h7FFF_FFFF;
               1: v = 32'h8000_0000;
               2: v = '0;
               default: v = '1;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // one request transaction, with random idle cycles ahead of it
   task automatic send_item(input ais_pkg::value_type v, input logic l);
      while (!quiet && $urandom_range(99) < 38) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_set(input int size);
      for (int i = 0; i < size; i++) begin
         send_item(pick_value(), i == size - 1);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // single element set
      send_item(32'sd0, 1'b1);
      // extremes out of order
      send_item(32'h7FFF_FFFF, 1'b0);
      send_item(32'h8000_0000, 1'b0);
      send_item(32'sd0, 1'b0);
      send_item(-32'sd1, 1'b0);
      send_item(32'sd1, 1'b1);
      // equal elements
      send_item(32'sd5, 1'b0);
      send_item(32'sd5, 1'b0);
      send_item(-32'sd3, 1'b0);
      send_item(32'sd5, 1'b1);

      // store overflows and the closing element itself is dropped
      send_set(ais_pkg::CAPACITY + 1);

      set_no = 0;
      while (items_sent < 170) begin
         quiet <= (set_no >= 3 && set_no <= 6);
         if (set_no == 5) begin
            send_set(ais_pkg::CAPACITY);
         end else begin
            send_set($urandom_range(1, 8));
         end
         set_no++;
      end
      req_tvalid <= 1'b0;
      quiet      <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
